### rtl/svcg_pkg.sv
// Shared types, constants and helper functions for the SVPWM compare generator.
package svcg_pkg;

    // Dwell-time fixed point: one equals 2**DQ
    localparam int DQ      = 24;
    localparam int ONE     = 1 << DQ;
    // Width of the raw product domain (inputs times Q.20 constants)
    localparam int PROD_W  = 40;
    // Clip limits are Q0.16, dwell domain is Q.24
    localparam int CLIP_SH = DQ - 16;

    localparam logic signed [21:0] K_SQRT3 = 22'sd1816238;
    localparam logic signed [21:0] K_0866  = 22'sd908067;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] IDX_DPWM   = 2'd0;
    localparam logic [1:0] IDX_PERIOD = 2'd1;
    localparam logic [1:0] IDX_DMIN   = 2'd2;
    localparam logic [1:0] IDX_DMAX   = 2'd3;

    localparam logic [15:0] RST_PERIOD = 16'd34000;
    localparam logic [15:0] RST_DMIN   = 16'd1311;
    localparam logic [15:0] RST_DMAX   = 16'd64225;

    // Sector numbers
    localparam logic [2:0] SEC_NONE = 3'd0;
    localparam logic [2:0] SEC_1    = 3'd1;
    localparam logic [2:0] SEC_2    = 3'd2;
    localparam logic [2:0] SEC_3    = 3'd3;
    localparam logic [2:0] SEC_4    = 3'd4;
    localparam logic [2:0] SEC_5    = 3'd5;
    localparam logic [2:0] SEC_6    = 3'd6;

    typedef struct packed {
        logic        min_clamp_en;
        logic [15:0] period_ticks;
        logic [15:0] clip_lo;
        logic [15:0] clip_hi;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  sector;
        logic        overmodulated;
        logic [15:0] set_a;
        logic [15:0] reset_a;
        logic [15:0] set_b;
        logic [15:0] reset_b;
        logic [15:0] set_c;
        logic [15:0] reset_c;
    } res_t;

    // Sign-test code {beta<=0, beta-sqrt3*alpha<=0, beta+sqrt3*alpha<=0} to sector
    function automatic logic [2:0] sector_of(input logic [2:0] code);
        logic [2:0] s;
        unique case (code)
            3'd0:    s = SEC_2;
            3'd1:    s = SEC_3;
            3'd2:    s = SEC_1;
            3'd5:    s = SEC_4;
            3'd6:    s = SEC_6;
            3'd7:    s = SEC_5;
            default: s = SEC_NONE;
        endcase
        return s;
    endfunction

endpackage

### rtl/svcg_sample_if.sv
// Input channel: one alpha/beta voltage pair per transaction.
interface svcg_sample_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] alpha_v;
    logic signed [17:0] beta_v;

    modport source (output valid, output alpha_v, output beta_v, input ready);
    modport sink   (input valid, input alpha_v, input beta_v, output ready);
endinterface

### rtl/svcg_result_if.sv
// Output channel: sector, overmodulation flag and three compare pairs per transaction.
interface svcg_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  sector;
    logic        overmodulated;
    logic [15:0] set_a;
    logic [15:0] reset_a;
    logic [15:0] set_b;
    logic [15:0] reset_b;
    logic [15:0] set_c;
    logic [15:0] reset_c;

    modport source (output valid, output sector, output overmodulated,
                    output set_a, output reset_a, output set_b, output reset_b,
                    output set_c, output reset_c, input ready);
    modport sink   (input valid, input sector, input overmodulated,
                    input set_a, input reset_a, input set_b, input reset_b,
                    input set_c, input reset_c, output ready);
endinterface

### rtl/svcg_regs.sv
// APB-style configuration register file.
module svcg_regs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [3:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output svcg_pkg::cfg_t  cfg
);
    import svcg_pkg::*;

    cfg_t       cfg_reg;
    logic       wr;
    logic [1:0] idx;

    assign wr  = psel && penable && pwrite;
    assign idx = paddr[3:2];
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_clamp_en <= 1'b0;
            cfg_reg.period_ticks <= RST_PERIOD;
            cfg_reg.clip_lo      <= RST_DMIN;
            cfg_reg.clip_hi      <= RST_DMAX;
        end
        else if (wr)
        begin
            unique case (idx)
                IDX_DPWM:   cfg_reg.min_clamp_en <= pwdata[0];
                IDX_PERIOD: cfg_reg.period_ticks <= pwdata[15:0];
                IDX_DMIN:   cfg_reg.clip_lo      <= pwdata[15:0];
                IDX_DMAX:   cfg_reg.clip_hi      <= pwdata[15:0];
                default:    cfg_reg.min_clamp_en <= cfg_reg.min_clamp_en;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            IDX_DPWM:   prdata = {31'd0, cfg_reg.min_clamp_en};
            IDX_PERIOD: prdata = {16'd0, cfg_reg.period_ticks};
            IDX_DMIN:   prdata = {16'd0, cfg_reg.clip_lo};
            IDX_DMAX:   prdata = {16'd0, cfg_reg.clip_hi};
            default:    prdata = 32'd0;
        endcase
    end
endmodule

### rtl/svcg_sector.sv
// Front stages: products, sector sign tests, dwell times rounded to Q.24, sum check.
module svcg_sector #(
    parameter int SHIFT = 12,
    parameter int TW    = 28
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic signed [17:0]   alpha_v,
    input  logic signed [17:0]   beta_v,
    output logic                 out_vld,
    output logic [2:0]           sector,
    output logic                 ovm,
    output logic signed [TW-1:0] t1,
    output logic signed [TW-1:0] t2,
    output logic signed [TW:0]   sum
);
    import svcg_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (SHIFT - 1);
    localparam logic signed [TW:0]       ONE_S = (TW + 1)'(ONE);

    // stage A
    logic                     a_vld_reg;
    logic signed [17:0]       be_a_reg;
    logic signed [PROD_W-1:0] ka_a_reg, ta_a_reg;
    logic signed [PROD_W-1:0] ka_next, ta_next;
    // stage B
    logic                     b_vld_reg;
    logic [2:0]               sec_b_reg, sec_b_next;
    logic signed [PROD_W-1:0] p_b_reg, m_b_reg, bq_b_reg;
    logic signed [PROD_W-1:0] bq, tb, p_next, m_next;
    logic [2:0]               code;
    // stage C
    logic                     c_vld_reg;
    logic [2:0]               sec_c_reg;
    logic signed [TW-1:0]     t1_c_reg, t2_c_reg, t1_next, t2_next;
    logic signed [PROD_W-1:0] t1w, t2w, r1, r2;
    // stage D
    logic                     d_vld_reg;
    logic [2:0]               sec_d_reg;
    logic                     ovm_d_reg;
    logic signed [TW-1:0]     t1_d_reg, t2_d_reg;
    logic signed [TW:0]       sum_d_reg, sum_next;

    assign ka_next = alpha_v * K_SQRT3;
    assign ta_next = alpha_v * K_0866;

    assign bq     = PROD_W'(be_a_reg) <<< 20;
    assign tb     = PROD_W'(be_a_reg) <<< 19;
    assign p_next = ta_a_reg + tb;
    assign m_next = ta_a_reg - tb;
    assign code   = {!(be_a_reg > 18'sd0), !((bq - ka_a_reg) > 0), !((bq + ka_a_reg) > 0)};
    assign sec_b_next = sector_of(code);

    always_comb
    begin
        unique case (sec_b_reg)
            SEC_1:   begin t1w = m_b_reg;   t2w = bq_b_reg;  end
            SEC_2:   begin t1w = p_b_reg;   t2w = -m_b_reg;  end
            SEC_3:   begin t1w = bq_b_reg;  t2w = -p_b_reg;  end
            SEC_4:   begin t1w = -m_b_reg;  t2w = -bq_b_reg; end
            SEC_5:   begin t1w = -p_b_reg;  t2w = m_b_reg;   end
            SEC_6:   begin t1w = -bq_b_reg; t2w = p_b_reg;   end
            default: begin t1w = '0;        t2w = '0;        end
        endcase
    end

    // round to nearest, ties up
    assign r1      = (t1w + HALF) >>> SHIFT;
    assign r2      = (t2w + HALF) >>> SHIFT;
    assign t1_next = TW'(r1);
    assign t2_next = TW'(r2);

    assign sum_next = (TW + 1)'(t1_c_reg) + (TW + 1)'(t2_c_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_vld;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            be_a_reg  <= beta_v;
            ka_a_reg  <= ka_next;
            ta_a_reg  <= ta_next;
            sec_b_reg <= sec_b_next;
            p_b_reg   <= p_next;
            m_b_reg   <= m_next;
            bq_b_reg  <= bq;
            sec_c_reg <= sec_b_reg;
            t1_c_reg  <= t1_next;
            t2_c_reg  <= t2_next;
            sec_d_reg <= sec_c_reg;
            t1_d_reg  <= t1_c_reg;
            t2_d_reg  <= t2_c_reg;
            sum_d_reg <= sum_next;
            ovm_d_reg <= sum_next > ONE_S;
        end
    end

    assign out_vld = d_vld_reg;
    assign sector  = sec_d_reg;
    assign ovm     = ovm_d_reg;
    assign t1      = t1_d_reg;
    assign t2      = t2_d_reg;
    assign sum     = sum_d_reg;
endmodule

### rtl/svcg_div.sv
// Pipelined restoring divider: |t|*2^24/sum for both dwell times, one quotient bit per stage.
module svcg_div #(
    parameter int TW = 28
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_vld,
    input  logic [2:0]           in_sector,
    input  logic                 in_ovm,
    input  logic signed [TW-1:0] in_t1,
    input  logic signed [TW-1:0] in_t2,
    input  logic signed [TW:0]   in_sum,
    output logic                 out_vld,
    output logic [2:0]           out_sector,
    output logic                 out_ovm,
    output logic signed [TW-1:0] out_t1,
    output logic signed [TW-1:0] out_t2,
    output logic [TW-1:0]        out_q1,
    output logic [TW-1:0]        out_q2
);
    import svcg_pkg::*;

    localparam int NS = TW + 1;

    logic                 vld_reg [NS];
    logic [2:0]           sec_reg [NS];
    logic                 ovm_reg [NS];
    logic signed [TW-1:0] t1_reg  [NS];
    logic signed [TW-1:0] t2_reg  [NS];
    logic [TW-1:0]        d_reg   [NS];
    logic [TW-1:0]        r1_reg  [NS];
    logic [TW-1:0]        r2_reg  [NS];
    logic [TW-1:0]        n1_reg  [NS];
    logic [TW-1:0]        n2_reg  [NS];
    logic [TW-1:0]        q1_reg  [NS];
    logic [TW-1:0]        q2_reg  [NS];

    logic [TW-1:0]        r1_next [NS];
    logic [TW-1:0]        r2_next [NS];
    logic [TW-1:0]        n1_next [NS];
    logic [TW-1:0]        n2_next [NS];
    logic [TW-1:0]        q1_next [NS];
    logic [TW-1:0]        q2_next [NS];

    logic [TW-1:0]        m1, m2;

    assign m1 = in_t1[TW-1] ? TW'(-in_t1) : TW'(in_t1);
    assign m2 = in_t2[TW-1] ? TW'(-in_t2) : TW'(in_t2);

    always_comb
    begin
        logic [TW:0] rs1, rs2, dd;
        // entry: high dividend bits start the remainder, low bits wait in n
        r1_next[0] = TW'(m1 >> (TW - DQ));
        r2_next[0] = TW'(m2 >> (TW - DQ));
        n1_next[0] = m1 << DQ;
        n2_next[0] = m2 << DQ;
        q1_next[0] = '0;
        q2_next[0] = '0;
        for (int k = 1; k < NS; k++)
        begin
            dd  = {1'b0, d_reg[k-1]};
            rs1 = {r1_reg[k-1], n1_reg[k-1][TW-1]};
            rs2 = {r2_reg[k-1], n2_reg[k-1][TW-1]};
            n1_next[k] = n1_reg[k-1] << 1;
            n2_next[k] = n2_reg[k-1] << 1;
            if (rs1 >= dd)
            begin
                r1_next[k] = TW'(rs1 - dd);
                q1_next[k] = {q1_reg[k-1][TW-2:0], 1'b1};
            end
            else
            begin
                r1_next[k] = TW'(rs1);
                q1_next[k] = {q1_reg[k-1][TW-2:0], 1'b0};
            end
            if (rs2 >= dd)
            begin
                r2_next[k] = TW'(rs2 - dd);
                q2_next[k] = {q2_reg[k-1][TW-2:0], 1'b1};
            end
            else
            begin
                r2_next[k] = TW'(rs2);
                q2_next[k] = {q2_reg[k-1][TW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= in_vld;
            for (int k = 1; k < NS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sec_reg[0] <= in_sector;
            ovm_reg[0] <= in_ovm;
            t1_reg[0]  <= in_t1;
            t2_reg[0]  <= in_t2;
            d_reg[0]   <= TW'(in_sum);
            for (int k = 1; k < NS; k++)
            begin
                sec_reg[k] <= sec_reg[k-1];
                ovm_reg[k] <= ovm_reg[k-1];
                t1_reg[k]  <= t1_reg[k-1];
                t2_reg[k]  <= t2_reg[k-1];
                d_reg[k]   <= d_reg[k-1];
            end
            for (int k = 0; k < NS; k++)
            begin
                r1_reg[k] <= r1_next[k];
                r2_reg[k] <= r2_next[k];
                n1_reg[k] <= n1_next[k];
                n2_reg[k] <= n2_next[k];
                q1_reg[k] <= q1_next[k];
                q2_reg[k] <= q2_next[k];
            end
        end
    end

    assign out_vld    = vld_reg[NS-1];
    assign out_sector = sec_reg[NS-1];
    assign out_ovm    = ovm_reg[NS-1];
    assign out_t1     = t1_reg[NS-1];
    assign out_t2     = t2_reg[NS-1];
    assign out_q1     = q1_reg[NS-1];
    assign out_q2     = q2_reg[NS-1];
endmodule

### rtl/svcg_duty.sv
// Back stages: scaled dwell select, phase duties, DPWM shift, clip and compare values.
module svcg_duty #(
    parameter int TW        = 28,
    parameter int TICK_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  svcg_pkg::cfg_t       cfg,
    input  logic                 in_vld,
    input  logic [2:0]           in_sector,
    input  logic                 in_ovm,
    input  logic signed [TW-1:0] in_t1,
    input  logic signed [TW-1:0] in_t2,
    input  logic [TW-1:0]        in_q1,
    input  logic [TW-1:0]        in_q2,
    output logic                 out_vld,
    output svcg_pkg::res_t       res
);
    import svcg_pkg::*;

    localparam int PW = (TICK_BITS < 16) ? TICK_BITS : 16;
    localparam int W2 = TW + 2;
    localparam int W3 = TW + 3;
    localparam int WT = W3 + PW + 1;
    localparam int WP = DQ + PW;
    localparam logic signed [W2-1:0] ONE_S = W2'(ONE);
    localparam logic signed [WT-1:0] HALF_TICK = WT'(ONE >> 1);

    logic [PW-1:0] per;
    assign per = cfg.period_ticks[PW-1:0];

    // stage E: pick scaled or raw dwell times
    logic                 e_vld_reg, e_ovm_reg;
    logic [2:0]           e_sec_reg;
    logic signed [TW-1:0] e_t1_reg, e_t2_reg, e_t1_next, e_t2_next;
    // stage F: zero-vector half
    logic                 f_vld_reg, f_ovm_reg;
    logic [2:0]           f_sec_reg;
    logic signed [W2-1:0] f_h_reg, f_t1_reg, f_t2_reg, f_t0;
    // stage G: phase duties
    logic                 g_vld_reg, g_ovm_reg;
    logic [2:0]           g_sec_reg;
    logic signed [W2-1:0] g_v_reg [3];
    logic signed [W2-1:0] g_v_next [3];
    // stage H: DPWM min subtract
    logic                 h_vld_reg, h_ovm_reg;
    logic [2:0]           h_sec_reg;
    logic signed [W3-1:0] h_d_reg [3];
    logic signed [W3-1:0] h_d_next [3];
    logic signed [W2-1:0] vmin;
    // stage I: clip
    logic                 i_vld_reg, i_ovm_reg;
    logic [2:0]           i_sec_reg;
    logic signed [W3-1:0] i_d_reg [3];
    logic [DQ-1:0]        i_dc_reg [3];
    logic [DQ-1:0]        i_dc_next [3];
    logic signed [W3-1:0] lo, hi;
    // stage J: products
    logic                 j_vld_reg, j_ovm_reg;
    logic [2:0]           j_sec_reg;
    logic                 j_clamp_reg [3];
    logic [PW-1:0]        j_pulse_reg [3];
    logic                 j_clamp_next [3];
    logic [PW-1:0]        j_pulse_next [3];
    // stage K: output register
    logic                 k_vld_reg;
    res_t                 k_res_reg, k_res_next;
    logic [PW-1:0]        k_set [3];
    logic [PW-1:0]        k_rst [3];

    // E
    always_comb
    begin
        if (in_ovm)
        begin
            e_t1_next = in_t1[TW-1] ? -$signed(in_q1) : $signed(in_q1);
            e_t2_next = in_t2[TW-1] ? -$signed(in_q2) : $signed(in_q2);
        end
        else
        begin
            e_t1_next = in_t1;
            e_t2_next = in_t2;
        end
    end

    // F
    assign f_t0 = ONE_S - W2'(e_t1_reg) - W2'(e_t2_reg);

    // G
    always_comb
    begin
        logic signed [W2-1:0] a1, a12, a2;
        a1  = f_h_reg + f_t1_reg;
        a2  = f_h_reg + f_t2_reg;
        a12 = a1 + f_t2_reg;
        unique case (f_sec_reg)
            SEC_1:   begin g_v_next[0] = a12;     g_v_next[1] = a2;      g_v_next[2] = f_h_reg; end
            SEC_2:   begin g_v_next[0] = a1;      g_v_next[1] = a12;     g_v_next[2] = f_h_reg; end
            SEC_3:   begin g_v_next[0] = f_h_reg; g_v_next[1] = a12;     g_v_next[2] = a2;      end
            SEC_4:   begin g_v_next[0] = f_h_reg; g_v_next[1] = a1;      g_v_next[2] = a12;     end
            SEC_5:   begin g_v_next[0] = a2;      g_v_next[1] = f_h_reg; g_v_next[2] = a12;     end
            SEC_6:   begin g_v_next[0] = a12;     g_v_next[1] = f_h_reg; g_v_next[2] = a1;      end
            default: begin g_v_next[0] = f_h_reg; g_v_next[1] = f_h_reg; g_v_next[2] = f_h_reg; end
        endcase
    end

    // H
    always_comb
    begin
        vmin = g_v_reg[0];
        if (g_v_reg[1] < vmin)
        begin
            vmin = g_v_reg[1];
        end
        if (g_v_reg[2] < vmin)
        begin
            vmin = g_v_reg[2];
        end
        for (int p = 0; p < 3; p++)
        begin
            if (cfg.min_clamp_en)
            begin
                h_d_next[p] = W3'(g_v_reg[p]) - W3'(vmin);
            end
            else
            begin
                h_d_next[p] = W3'(g_v_reg[p]);
            end
        end
    end

    // I: low limit test first, then high limit
    assign lo = $signed({{(W3 - 16 - CLIP_SH){1'b0}}, cfg.clip_lo, {CLIP_SH{1'b0}}});
    assign hi = $signed({{(W3 - 16 - CLIP_SH){1'b0}}, cfg.clip_hi, {CLIP_SH{1'b0}}});

    always_comb
    begin
        for (int p = 0; p < 3; p++)
        begin
            priority if (h_d_reg[p] < lo)
            begin
                i_dc_next[p] = DQ'(lo);
            end
            else if (h_d_reg[p] > hi)
            begin
                i_dc_next[p] = DQ'(hi);
            end
            else
            begin
                i_dc_next[p] = DQ'(h_d_reg[p]);
            end
        end
    end

    // J: half-tick test is 2*d*P < one
    always_comb
    begin
        logic signed [WT-1:0] tp;
        logic [WP-1:0]        pp;
        for (int p = 0; p < 3; p++)
        begin
            tp = i_d_reg[p] * $signed({1'b0, per});
            pp = i_dc_reg[p] * per;
            j_clamp_next[p] = cfg.min_clamp_en && (tp < HALF_TICK);
            j_pulse_next[p] = PW'(pp >> DQ);
        end
    end

    // K
    always_comb
    begin
        logic [PW-1:0] half;
        for (int p = 0; p < 3; p++)
        begin
            half = (per - j_pulse_reg[p]) >> 1;
            if (j_clamp_reg[p])
            begin
                k_set[p] = per + PW'(1);
                k_rst[p] = per >> 1;
            end
            else
            begin
                k_set[p] = half;
                k_rst[p] = half + j_pulse_reg[p];
            end
        end
        k_res_next.sector        = j_sec_reg;
        k_res_next.overmodulated = j_ovm_reg;
        k_res_next.set_a         = 16'(k_set[0]);
        k_res_next.reset_a       = 16'(k_rst[0]);
        k_res_next.set_b         = 16'(k_set[1]);
        k_res_next.reset_b       = 16'(k_rst[1]);
        k_res_next.set_c         = 16'(k_set[2]);
        k_res_next.reset_c       = 16'(k_rst[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
            h_vld_reg <= 1'b0;
            i_vld_reg <= 1'b0;
            j_vld_reg <= 1'b0;
            k_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            e_vld_reg <= in_vld;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
            h_vld_reg <= g_vld_reg;
            i_vld_reg <= h_vld_reg;
            j_vld_reg <= i_vld_reg;
            k_vld_reg <= j_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_sec_reg <= in_sector;
            e_ovm_reg <= in_ovm;
            e_t1_reg  <= e_t1_next;
            e_t2_reg  <= e_t2_next;

            f_sec_reg <= e_sec_reg;
            f_ovm_reg <= e_ovm_reg;
            f_h_reg   <= f_t0 >>> 1;
            f_t1_reg  <= W2'(e_t1_reg);
            f_t2_reg  <= W2'(e_t2_reg);

            g_sec_reg <= f_sec_reg;
            g_ovm_reg <= f_ovm_reg;
            h_sec_reg <= g_sec_reg;
            h_ovm_reg <= g_ovm_reg;
            i_sec_reg <= h_sec_reg;
            i_ovm_reg <= h_ovm_reg;
            j_sec_reg <= i_sec_reg;
            j_ovm_reg <= i_ovm_reg;
            for (int p = 0; p < 3; p++)
            begin
                g_v_reg[p]     <= g_v_next[p];
                h_d_reg[p]     <= h_d_next[p];
                i_d_reg[p]     <= h_d_reg[p];
                i_dc_reg[p]    <= i_dc_next[p];
                j_clamp_reg[p] <= j_clamp_next[p];
                j_pulse_reg[p] <= j_pulse_next[p];
            end
            k_res_reg <= k_res_next;
        end
    end

    assign out_vld = k_vld_reg;
    assign res     = k_res_reg;
endmodule

### rtl/svpwm_centered_compare_gen_unit.sv
// Pipeline: 4 front stages + TW+1 divider stages + 7 back stages.
// Throughput: one transaction per cycle unless the output stalls; one divider stage per quotient bit.
// TW = max(40 - (FRAC_BITS - 4), 26), the dwell-time width set by FRAC_BITS.
// The whole pipeline advances when the output register is empty or being taken.
// Reset: async active low; clears valid bits and loads register reset values.
module svpwm_centered_compare_gen_unit #(
    parameter int FRAC_BITS = 16,
    parameter int TICK_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    svcg_sample_if.sink   sample,
    svcg_result_if.source result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import svcg_pkg::*;

    // product fraction bits (FRAC_BITS + 20) minus Q.24
    localparam int SHIFT = FRAC_BITS + 20 - DQ;
    localparam int TW    = (PROD_W - SHIFT > 26) ? PROD_W - SHIFT : 26;

    cfg_t                 cfg;
    res_t                 res;
    logic                 en;
    logic                 out_vld;

    logic                 s_vld, s_ovm;
    logic [2:0]           s_sec;
    logic signed [TW-1:0] s_t1, s_t2;
    logic signed [TW:0]   s_sum;

    logic                 d_vld, d_ovm;
    logic [2:0]           d_sec;
    logic signed [TW-1:0] d_t1, d_t2;
    logic [TW-1:0]        d_q1, d_q2;

    // Global stall: every stage moves together unless the output register holds
    // a transaction the sink has not taken.
    assign en           = !out_vld || result.ready;
    assign sample.ready = en;
    assign pready       = 1'b1;

    svcg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // sign tests, sector and rounded dwell times
    svcg_sector #(
        .SHIFT (SHIFT),
        .TW    (TW)
    ) u_sector (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (sample.valid),
        .alpha_v (sample.alpha_v),
        .beta_v  (sample.beta_v),
        .out_vld (s_vld),
        .sector  (s_sec),
        .ovm     (s_ovm),
        .t1      (s_t1),
        .t2      (s_t2),
        .sum     (s_sum)
    );

    // overmodulation scaling t*one/sum
    svcg_div #(
        .TW (TW)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_vld     (s_vld),
        .in_sector  (s_sec),
        .in_ovm     (s_ovm),
        .in_t1      (s_t1),
        .in_t2      (s_t2),
        .in_sum     (s_sum),
        .out_vld    (d_vld),
        .out_sector (d_sec),
        .out_ovm    (d_ovm),
        .out_t1     (d_t1),
        .out_t2     (d_t2),
        .out_q1     (d_q1),
        .out_q2     (d_q2)
    );

    // duties, DPWM clamp, clip and centered compares
    svcg_duty #(
        .TW        (TW),
        .TICK_BITS (TICK_BITS)
    ) u_duty (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .in_vld    (d_vld),
        .in_sector (d_sec),
        .in_ovm    (d_ovm),
        .in_t1     (d_t1),
        .in_t2     (d_t2),
        .in_q1     (d_q1),
        .in_q2     (d_q2),
        .out_vld   (out_vld),
        .res       (res)
    );

    assign result.valid         = out_vld;
    assign result.sector        = res.sector;
    assign result.overmodulated = res.overmodulated;
    assign result.set_a         = res.set_a;
    assign result.reset_a       = res.reset_a;
    assign result.set_b         = res.set_b;
    assign result.reset_b       = res.reset_b;
    assign result.set_c         = res.set_c;
    assign result.reset_c       = res.reset_c;
endmodule

### test/svpwm_centered_compare_gen_unit_tb.sv
// Testbench for the SVPWM centered compare generator: directed and random checks.
module svpwm_centered_compare_gen_unit_tb;
    import svcg_pkg::*;

    localparam int SETTLE_CYCLES = 60;     // pipeline is 40 deep at default params
    localparam int CYCLE_LIMIT   = 500000;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    svcg_sample_if smp ();
    svcg_result_if res ();

    svpwm_centered_compare_gen_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (smp.sink),
        .result  (res.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the register file, mirrors every APB write.
    cfg_t shadow_cfg;

    // Predicted compare results, oldest first.
    res_t pending_compares[$];

    int unsigned cycle_count;
    int unsigned mismatch_count;
    int unsigned accepted_count;
    int unsigned checked_count;
    int unsigned overmod_count;
    logic [6:0]  sectors_seen;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Product domain (FRAC_BITS+20 fraction bits) to Q.24, round half up.
    function automatic longint round_to_dwell(longint x);
        return (x + 64'sd2048) >>> 12;
    endfunction

    // One phase duty (Q.24) to {set, reset} compares under the shadow config.
    function automatic logic [31:0] duty_to_compares(longint duty);
        longint      per;
        longint      lo;
        longint      hi;
        longint      pulse;
        longint      half;
        logic [15:0] set_v;
        logic [15:0] rst_v;
        per = longint'(shadow_cfg.period_ticks);
        if (shadow_cfg.min_clamp_en && (2 * duty * per < (64'sd1 <<< DQ)))
        begin
            // phase held off: set beyond the period, reset at mid-period
            set_v = 16'(per + 1);
            rst_v = 16'(per / 2);
            return {set_v, rst_v};
        end
        lo = longint'(shadow_cfg.clip_lo) <<< CLIP_SH;
        hi = longint'(shadow_cfg.clip_hi) <<< CLIP_SH;
        // low limit wins over high limit when the window is inverted
        if (duty < lo)
            duty = lo;
        else if (duty > hi)
            duty = hi;
        pulse = (duty * per) >>> DQ;
        half  = (per - pulse) / 2;
        set_v = 16'(half);
        rst_v = 16'(half + pulse);
        return {set_v, rst_v};
    endfunction

    function automatic res_t predict_compares(logic signed [17:0] alpha, logic signed [17:0] beta);
        longint     al;
        longint     be;
        longint     bq;
        longint     ta;
        longint     tb;
        longint     one;
        longint     t1w;
        longint     t2w;
        longint     t1;
        longint     t2;
        longint     sum;
        longint     h;
        longint     va;
        longint     vb;
        longint     vc;
        longint     vmin;
        logic [2:0] code;
        logic [2:0] sec;
        logic [31:0] pa;
        logic [31:0] pb;
        logic [31:0] pc;
        res_t       r;
        al  = alpha;
        be  = beta;
        bq  = be * 64'sd1048576;
        ta  = al * 64'sd908067;
        tb  = be * 64'sd524288;
        one = 64'sd1 <<< DQ;
        code = {!(be > 0), !(bq - 64'sd1816238 * al > 0), !(bq + 64'sd1816238 * al > 0)};
        case (code)
            3'd0:    sec = SEC_2;
            3'd1:    sec = SEC_3;
            3'd2:    sec = SEC_1;
            3'd5:    sec = SEC_4;
            3'd6:    sec = SEC_6;
            3'd7:    sec = SEC_5;
            default: sec = SEC_NONE;
        endcase
        t1w = 0;
        t2w = 0;
        case (sec)
            SEC_1:   begin t1w = ta - tb;  t2w = bq;       end
            SEC_2:   begin t1w = ta + tb;  t2w = -ta + tb; end
            SEC_3:   begin t1w = bq;       t2w = -ta - tb; end
            SEC_4:   begin t1w = -ta + tb; t2w = -bq;      end
            SEC_5:   begin t1w = -ta - tb; t2w = ta - tb;  end
            SEC_6:   begin t1w = -bq;      t2w = ta + tb;  end
            default: ;  // unreachable pattern: zero dwell times
        endcase
        t1  = round_to_dwell(t1w);
        t2  = round_to_dwell(t2w);
        sum = t1 + t2;
        r.overmodulated = 1'b0;
        if (sum > one)
        begin
            // scale back onto the hexagon edge, truncating toward zero
            r.overmodulated = 1'b1;
            t1 = (t1 * one) / sum;
            t2 = (t2 * one) / sum;
        end
        h = (one - t1 - t2) >>> 1;
        case (sec)
            SEC_1:   begin va = h + t1 + t2; vb = h + t2;      vc = h;           end
            SEC_2:   begin va = h + t1;      vb = h + t1 + t2; vc = h;           end
            SEC_3:   begin va = h;           vb = h + t1 + t2; vc = h + t2;      end
            SEC_4:   begin va = h;           vb = h + t1;      vc = h + t1 + t2; end
            SEC_5:   begin va = h + t2;      vb = h;           vc = h + t1 + t2; end
            SEC_6:   begin va = h + t1 + t2; vb = h;           vc = h + t1;      end
            default: begin va = h;           vb = h;           vc = h;           end
        endcase
        if (shadow_cfg.min_clamp_en)
        begin
            vmin = va;
            if (vb < vmin)
                vmin = vb;
            if (vc < vmin)
                vmin = vc;
            va -= vmin;
            vb -= vmin;
            vc -= vmin;
        end
        pa = duty_to_compares(va);
        pb = duty_to_compares(vb);
        pc = duty_to_compares(vc);
        r.sector  = sec;
        r.set_a   = pa[31:16];
        r.reset_a = pa[15:0];
        r.set_b   = pb[31:16];
        r.reset_b = pb[15:0];
        r.set_c   = pc[31:16];
        r.reset_c = pc[15:0];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared stimulus tasks (called just after a rising edge)
    // ------------------------------------------------------------------

    // Drive one voltage pair and hold it until the transaction completes.
    task automatic send_voltage(logic signed [17:0] alpha, logic signed [17:0] beta);
        res_t predicted;
        smp.valid   <= 1'b1;
        smp.alpha_v <= alpha;
        smp.beta_v  <= beta;
        do
            @(posedge clk);
        while (!smp.ready);
        predicted = predict_compares(alpha, beta);
        pending_compares.push_back(predicted);
        accepted_count++;
        if (predicted.overmodulated)
            overmod_count++;
        sectors_seen[predicted.sector] = 1'b1;
        // Idle cycles after the transaction, each drawn with the idle percentage
        if ($urandom_range(99) < send_idle_pct)
        begin
            smp.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Lower valid and let the pipeline empty out completely.
    task automatic drain_pipeline();
        smp.valid <= 1'b0;
        @(posedge clk);
        while (pending_compares.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle; pready is always high.
    // The bus is left selected; load_config releases it after the last write.
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            IDX_DPWM:   shadow_cfg.min_clamp_en = value[0];
            IDX_PERIOD: shadow_cfg.period_ticks = value[15:0];
            IDX_DMIN:   shadow_cfg.clip_lo      = value[15:0];
            default:    shadow_cfg.clip_hi      = value[15:0];
        endcase
    endtask

    task automatic load_config(logic mode, logic [15:0] per, logic [15:0] dmin,
                               logic [15:0] dmax);
        write_reg(IDX_DPWM, {31'd0, mode});
        write_reg(IDX_PERIOD, {16'd0, per});
        write_reg(IDX_DMIN, {16'd0, dmin});
        write_reg(IDX_DMAX, {16'd0, dmax});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mix of full-scale, unit-circle-sized and small vectors.
    task automatic send_random_voltage();
        logic signed [17:0] a;
        logic signed [17:0] b;
        case ($urandom_range(2))
            0:
            begin
                a = 18'($urandom);
                b = 18'($urandom);
            end
            1:
            begin
                a = 18'($signed($urandom_range(131072)) - 65536);
                b = 18'($signed($urandom_range(131072)) - 65536);
            end
            default:
            begin
                a = 18'($signed($urandom_range(32768)) - 16384);
                b = 18'($signed($urandom_range(32768)) - 16384);
            end
        endcase
        send_voltage(a, b);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, sector boundaries and the sqrt3 diagonals.
    task automatic directed_vectors();
        send_voltage(18'sd0, 18'sd0);
        send_voltage(18'sd131071, 18'sd0);
        send_voltage(-18'sd131072, 18'sd0);
        send_voltage(18'sd0, 18'sd131071);
        send_voltage(18'sd0, -18'sd131072);
        send_voltage(18'sd131071, 18'sd131071);
        send_voltage(-18'sd131072, -18'sd131072);
        send_voltage(18'sd131071, -18'sd131072);
        send_voltage(-18'sd131072, 18'sd131071);
        send_voltage(18'sd37837, 18'sd65536);     // on the 60 degree line
        send_voltage(-18'sd37837, 18'sd65536);    // on the 120 degree line
        send_voltage(18'sd37837, -18'sd65536);
        send_voltage(-18'sd37837, -18'sd65536);
        send_voltage(18'sd56756, 18'sd32768);     // sector 1, unit magnitude
        send_voltage(18'sd0, 18'sd65536);
        send_voltage(-18'sd56756, -18'sd32768);
        send_voltage(18'sd1, 18'sd1);
        send_voltage(-18'sd1, -18'sd1);
        send_voltage(18'sd10, -18'sd1);
        send_voltage(18'sd75000, 18'sd0);         // just inside the hexagon edge
    endtask

    task automatic test_directed_symmetric();
        drain_pipeline();
        load_config(1'b0, RST_PERIOD, RST_DMIN, RST_DMAX);
        directed_vectors();
    endtask

    task automatic test_directed_dpwm();
        drain_pipeline();
        load_config(1'b1, 16'd34000, 16'd1311, 16'd64225);
        directed_vectors();
    endtask

    // Register extremes: tiny and huge periods, zero period, inverted window.
    task automatic test_config_corners();
        drain_pipeline();
        load_config(1'b0, 16'd16, 16'd0, 16'd65535);
        repeat (40) send_random_voltage();
        drain_pipeline();
        load_config(1'b1, 16'd65535, 16'd0, 16'd0);
        repeat (40) send_random_voltage();
        drain_pipeline();
        load_config(1'b0, 16'd0, 16'd40000, 16'd20000);
        repeat (40) send_random_voltage();
        drain_pipeline();
        load_config(1'b1, 16'd0, 16'd65535, 16'd65535);
        repeat (40) send_random_voltage();
        drain_pipeline();
        load_config(1'b0, 16'd65534, 16'd65535, 16'd0);
        repeat (40) send_random_voltage();
    endtask

    // Random traffic in several register settings, with a full stop midway.
    task automatic test_random_traffic(int unsigned items);
        for (int unsigned k = 0; k < items; k++)
        begin
            if (k % 150 == 0)
            begin
                drain_pipeline();
                load_config(1'($urandom), 16'($urandom_range(16, 65534)),
                            16'($urandom_range(0, 4000)), 16'($urandom_range(60000, 65535)));
            end
            else if (k % 150 == 75)
                drain_pipeline();   // sender holds off until every result is in
            send_random_voltage();
        end
    endtask

    // ------------------------------------------------------------------
    // Result checking and receiver stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got = '{res.sector, res.overmodulated, res.set_a, res.reset_a,
                    res.set_b, res.reset_b, res.set_c, res.reset_c};
            if (pending_compares.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: %p", got);
            end
            else
            begin
                want = pending_compares.pop_front();
                checked_count++;
                if (got.sector != want.sector || got.overmodulated != want.overmodulated
                    || got.set_a != want.set_a || got.reset_a != want.reset_a
                    || got.set_b != want.set_b || got.reset_b != want.reset_b
                    || got.set_c != want.set_c || got.reset_c != want.reset_c)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch #%0d exp %p got %p", checked_count, want, got);
                end
            end
        end
        res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("svpwm_centered_compare_gen_unit_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        smp.valid      = 1'b0;
        smp.alpha_v    = '0;
        smp.beta_v     = '0;
        res.ready      = 1'b0;
        cycle_count    = 0;
        mismatch_count = 0;
        accepted_count = 0;
        checked_count  = 0;
        overmod_count  = 0;
        sectors_seen   = '0;
        send_idle_pct  = 30;
        recv_idle_pct  = 47;
        shadow_cfg     = '{1'b0, RST_PERIOD, RST_DMIN, RST_DMAX};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first, before any register write
        directed_vectors();
        test_directed_symmetric();
        test_directed_dpwm();
        test_config_corners();
        test_random_traffic(450);
        send_idle_pct = 47;
        recv_idle_pct = 30;
        test_random_traffic(450);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(600);

        drain_pipeline();
        $display("covered %0d transactions, %0d overmodulated, sectors seen %b",
                 accepted_count, overmod_count, sectors_seen);
        $display("both modes, period/window extremes, three idle profiles, %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0 && pending_compares.size() == 0)
            $display("svpwm_centered_compare_gen_unit_tb OK");
        else
            $display("svpwm_centered_compare_gen_unit_tb NOT OK");
        $finish;
    end
endmodule
